@@ rtl/core/vdk3_pkg.sv @@
// vdk3_pkg: shared constants, types and trellis helper for the k=3 soft viterbi decoder
// used by vdk3_ctrl, vdk3_dp and viterbi_decoder_k3_soft_core; depends on nothing else

package vdk3_pkg;

    // sizing
    localparam int MAX_STEPS  = 512;
    localparam int SOFT_WIDTH = 8;
    localparam int NSTATES    = 4;
    localparam int PM_W       = 24;
    localparam int LVL_W      = 7;
    localparam logic [LVL_W-1:0] LVL_RESET = 7'd64;
    localparam logic [PM_W-1:0]  WORST     = {PM_W{1'b1}};

    localparam int STEP_W   = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W   = $clog2(MAX_STEPS);
    localparam int NBYTES   = (MAX_STEPS + 7) / 8;
    localparam int BYTE_AW  = (NBYTES > 1) ? $clog2(NBYTES) : 1;

    // soft arithmetic widths
    localparam int DIFF_W = ((SOFT_WIDTH > LVL_W + 1) ? SOFT_WIDTH : LVL_W + 1) + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int BM_W   = SQ_W + 1;

    // stream word widths
    localparam int IN_W  = ((2 * SOFT_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = 16;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BM,
        ST_ACS,
        ST_NORM,
        ST_BEST,
        ST_TB_RD,
        ST_TB_UP,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic take;
        logic bm_en;
        logic acs_en;
        logic norm_en;
        logic best_en;
        logic tb_rd;
        logic tb_up;
        logic out_rd;
        logic out_ld;
        logic blk_clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic blk_end;
        logic tb_last;
        logic out_taken;
        logic out_final;
    } t_status;

    // expected code bits {c1, c2} for a branch leaving state 'from' on input 'bit_in'
    function automatic logic [1:0] code_bits(input logic [1:0] from, input logic bit_in);
        logic [2:0] sr;
        sr = {from, bit_in};
        return {^sr, sr[2] ^ sr[0]};
    endfunction

endpackage

@@ rtl/core/vdk3_ctrl.sv @@
// vdk3_ctrl: sequencing state machine for the k=3 soft viterbi decoder
// depends on vdk3_pkg; drives vdk3_dp through t_cmd and reads t_status

module vdk3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tlast,
    input  vdk3_pkg::t_status i_status,
    output vdk3_pkg::t_cmd    o_cmd
);

    vdk3_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdk3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            vdk3_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.take = 1'b1;
                    if (!i_status.full) begin
                        n_state = vdk3_pkg::ST_BM;
                    end else if (i_s_tlast) begin
                        n_state = vdk3_pkg::ST_BEST;
                    end
                end
            end
            vdk3_pkg::ST_BM: begin
                o_cmd.bm_en = 1'b1;
                n_state     = vdk3_pkg::ST_ACS;
            end
            vdk3_pkg::ST_ACS: begin
                o_cmd.acs_en = 1'b1;
                n_state      = vdk3_pkg::ST_NORM;
            end
            vdk3_pkg::ST_NORM: begin
                o_cmd.norm_en = 1'b1;
                n_state = i_status.blk_end ? vdk3_pkg::ST_BEST : vdk3_pkg::ST_IDLE;
            end
            vdk3_pkg::ST_BEST: begin
                o_cmd.best_en = 1'b1;
                n_state       = vdk3_pkg::ST_TB_RD;
            end
            vdk3_pkg::ST_TB_RD: begin
                o_cmd.tb_rd = 1'b1;
                n_state     = vdk3_pkg::ST_TB_UP;
            end
            vdk3_pkg::ST_TB_UP: begin
                o_cmd.tb_up = 1'b1;
                n_state = i_status.tb_last ? vdk3_pkg::ST_OUT_RD : vdk3_pkg::ST_TB_RD;
            end
            vdk3_pkg::ST_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = vdk3_pkg::ST_OUT_LD;
            end
            vdk3_pkg::ST_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = vdk3_pkg::ST_OUT_WAIT;
            end
            vdk3_pkg::ST_OUT_WAIT: begin
                if (i_status.out_taken) begin
                    if (i_status.out_final) begin
                        o_cmd.blk_clr = 1'b1;
                        n_state       = vdk3_pkg::ST_IDLE;
                    end else begin
                        n_state = vdk3_pkg::ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = vdk3_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/vdk3_dp.sv @@
// vdk3_dp: datapath of the k=3 soft viterbi decoder: branch metrics, add-compare-select,
// survivor and byte memories, traceback and output word register; depends on vdk3_pkg

module vdk3_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vdk3_pkg::t_cmd                   i_cmd,
    output vdk3_pkg::t_status                o_status,
    input  logic [vdk3_pkg::IN_W-1:0]        i_s_tdata,
    input  logic                             i_s_tlast,
    input  logic                             i_cfg_wr_en,
    input  logic [vdk3_pkg::LVL_W-1:0]       i_cfg_wr_data,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [vdk3_pkg::OUT_W-1:0]       o_m_tdata,
    output logic                             o_m_tlast,
    output logic [0:0]                       o_m_tuser
);

    localparam int SW  = vdk3_pkg::SOFT_WIDTH;
    localparam int DW  = vdk3_pkg::DIFF_W;
    localparam int QW  = vdk3_pkg::SQ_W;
    localparam int BW  = vdk3_pkg::BM_W;
    localparam int PW  = vdk3_pkg::PM_W;
    localparam int AW  = vdk3_pkg::ADDR_W;
    localparam int STW = vdk3_pkg::STEP_W;
    localparam int KW  = vdk3_pkg::BYTE_AW;
    localparam int NS  = vdk3_pkg::NSTATES;

    // saturating path extension, worst stays worst
    function automatic logic [PW-1:0] add_sat(input logic [PW-1:0] pm, input logic [BW-1:0] bm);
        logic [PW:0] s;
        s = {1'b0, pm} + (PW+1)'(bm);
        if (pm == vdk3_pkg::WORST || s > {1'b0, vdk3_pkg::WORST}) begin
            return vdk3_pkg::WORST;
        end
        return s[PW-1:0];
    endfunction

    logic [vdk3_pkg::LVL_W-1:0] r_level;
    logic signed [SW-1:0]       r_soft_a, r_soft_b;
    logic                       r_end;
    logic [QW-1:0]              r_sq_a [2];
    logic [QW-1:0]              r_sq_b [2];
    logic [PW-1:0]              r_pm [NS];
    logic [PW-1:0]              r_nm [NS];
    logic [STW-1:0]             r_step;
    logic                       r_ovf;
    logic [1:0]                 r_cur;
    logic [AW-1:0]              r_tb_t;
    logic [NS-1:0]              r_rd_dec;
    logic [7:0]                 r_byte;
    logic [KW-1:0]              r_k;
    logic [7:0]                 r_pk_rd;
    logic [7:0]                 r_out_data;
    logic [3:0]                 r_out_cnt;
    logic                       r_out_ovf;
    logic                       r_out_last;
    logic                       r_out_valid;

    logic [NS-1:0]              mem_surv [vdk3_pkg::MAX_STEPS];
    logic [7:0]                 mem_pack [vdk3_pkg::NBYTES];

    logic signed [DW-1:0]       lvl_s;
    logic signed [DW-1:0]       da0, da1, db0, db1;
    logic signed [QW-1:0]       pa0, pa1, pb0, pb1;
    logic [PW-1:0]              n_nm [NS];
    logic [NS-1:0]              n_dec;
    logic [PW-1:0]              m01, m23, mn;
    logic [1:0]                 best;
    logic [7:0]                 n_byte;
    logic [KW-1:0]              last_k;
    logic                       out_taken;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= vdk3_pkg::LVL_RESET;
        end else if (i_cfg_wr_en) begin
            r_level <= i_cfg_wr_data;
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_soft_a <= i_s_tdata[SW-1:0];
            r_soft_b <= i_s_tdata[2*SW-1:SW];
            r_end    <= i_s_tlast;
        end
    end

    // distances to plus and minus the reference level, squared
    always_comb begin
        lvl_s = DW'($signed({1'b0, r_level}));
        da0   = DW'(r_soft_a) - lvl_s;
        da1   = DW'(r_soft_a) + lvl_s;
        db0   = DW'(r_soft_b) - lvl_s;
        db1   = DW'(r_soft_b) + lvl_s;
        pa0   = da0 * da0;
        pa1   = da1 * da1;
        pb0   = db0 * db0;
        pb1   = db1 * db1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bm_en) begin
            r_sq_a[0] <= QW'(pa0);
            r_sq_a[1] <= QW'(pa1);
            r_sq_b[0] <= QW'(pb0);
            r_sq_b[1] <= QW'(pb1);
        end
    end

    // add-compare-select, lower predecessor wins ties
    always_comb begin
        logic [1:0]    lo, hi, cl, ch;
        logic          bit_in;
        logic [PW-1:0] cand_l, cand_h;
        n_dec = '0;
        for (int n = 0; n < NS; n++) begin
            bit_in = n[0];
            lo     = 2'(n >> 1);
            hi     = lo | 2'b10;
            cl     = vdk3_pkg::code_bits(lo, bit_in);
            ch     = vdk3_pkg::code_bits(hi, bit_in);
            cand_l = add_sat(r_pm[lo], BW'(r_sq_a[cl[1]]) + BW'(r_sq_b[cl[0]]));
            cand_h = add_sat(r_pm[hi], BW'(r_sq_a[ch[1]]) + BW'(r_sq_b[ch[0]]));
            if (cand_h < cand_l) begin
                n_nm[n]  = cand_h;
                n_dec[n] = 1'b1;
            end else begin
                n_nm[n] = cand_l;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acs_en) begin
            r_nm <= n_nm;
        end
    end

    // survivor memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.acs_en) begin
            mem_surv[r_step[AW-1:0]] <= n_dec;
        end
        if (i_cmd.tb_rd) begin
            r_rd_dec <= mem_surv[r_tb_t];
        end
    end

    // minimum of the new metrics for normalisation
    always_comb begin
        m01 = (r_nm[1] < r_nm[0]) ? r_nm[1] : r_nm[0];
        m23 = (r_nm[3] < r_nm[2]) ? r_nm[3] : r_nm[2];
        mn  = (m23 < m01) ? m23 : m01;
    end

    // path metrics, step count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.blk_clr) begin
            r_pm[0] <= '0;
            for (int n = 1; n < NS; n++) begin
                r_pm[n] <= vdk3_pkg::WORST;
            end
            r_step <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cmd.norm_en) begin
                for (int n = 0; n < NS; n++) begin
                    r_pm[n] <= (r_nm[n] == vdk3_pkg::WORST) ? vdk3_pkg::WORST : r_nm[n] - mn;
                end
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.take && o_status.full) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // best end state, lowest index on ties
    always_comb begin
        best = 2'd0;
        for (int n = 1; n < NS; n++) begin
            if (r_pm[n] < r_pm[best]) begin
                best = 2'(n);
            end
        end
    end

    // next byte under assembly during traceback
    always_comb begin
        n_byte = r_byte;
        if (r_cur[0]) begin
            n_byte = r_byte | (8'h80 >> r_tb_t[2:0]);
        end
    end

    // traceback walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.best_en) begin
            r_cur  <= best;
            r_tb_t <= AW'(r_step - 1'b1);
            r_byte <= '0;
        end else if (i_cmd.tb_up) begin
            r_cur  <= {r_rd_dec[r_cur], r_cur[1]};
            r_tb_t <= r_tb_t - 1'b1;
            r_byte <= (r_tb_t[2:0] == 3'd0) ? 8'd0 : n_byte;
        end
    end

    // decoded byte memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.tb_up && r_tb_t[2:0] == 3'd0) begin
            mem_pack[KW'(r_tb_t >> 3)] <= n_byte;
        end
        if (i_cmd.out_rd) begin
            r_pk_rd <= mem_pack[r_k];
        end
    end

    assign last_k    = KW'((r_step - 1'b1) >> 3);
    assign out_taken = r_out_valid && i_m_tready;

    // byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.best_en) begin
            r_k <= '0;
        end else if (out_taken) begin
            r_k <= r_k + 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_data <= r_pk_rd;
            r_out_ovf  <= r_ovf;
            r_out_last <= (r_k == last_k);
            if (r_k == last_k && r_step[2:0] != 3'd0) begin
                r_out_cnt <= {1'b0, r_step[2:0]};
            end else begin
                r_out_cnt <= 4'd8;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_cnt, r_out_data};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_ovf;

    // status back to the controller
    always_comb begin
        o_status.full      = (r_step == STW'(vdk3_pkg::MAX_STEPS));
        o_status.blk_end   = r_end;
        o_status.tb_last   = (r_tb_t == '0);
        o_status.out_taken = out_taken;
        o_status.out_final = r_out_last;
    end

endmodule

@@ rtl/core/viterbi_decoder_k3_soft_core.sv @@
// viterbi_decoder_k3_soft_core: top level of the rate-1/2, k=3 (7,5) soft-decision viterbi decoder
// depends on vdk3_pkg, vdk3_ctrl and vdk3_dp
// input: symbol pairs one at a time, each through accept, branch metrics, acs and normalise before the next is taken
// block end: best-state search, then a survivor memory read and an update for each stored pair of traceback,
// then for each output byte a byte memory read, a register load and a wait while the sink stalls
// reset: synchronous active-low; clears control, metrics, step count, overflow; level 64; memories kept

module viterbi_decoder_k3_soft_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave word: soft_a [7:0], soft_b [15:8]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [vdk3_pkg::IN_W-1:0]    s_tdata,
    input  logic                         s_tlast,
    // master word: data_byte [7:0], bit_count [11:8], zero above
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vdk3_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tlast,
    // master user: overflow [0]
    output logic [0:0]                   m_tuser,
    input  logic                         i_cfg_wr_en,
    input  logic [vdk3_pkg::LVL_W-1:0]   i_cfg_wr_data
);

    vdk3_pkg::t_cmd    cmd;
    vdk3_pkg::t_status status;

    // sequencer
    vdk3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tlast  (s_tlast),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    vdk3_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_s_tdata     (s_tdata),
        .i_s_tlast     (s_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tlast     (m_tlast),
        .o_m_tuser     (m_tuser)
    );

    assign s_tready = cmd.in_ready;

endmodule
